>>> rtl/core/ghcr_pkg.sv
// ----------------------------------------------------------------------------
// ghcr_pkg
// Shared types, codes and flash tables of the host command responder.
// ----------------------------------------------------------------------------
package ghcr_pkg;

  localparam int REPORT_BYTES = 64;
  localparam int IDX_W        = $clog2(REPORT_BYTES);
  localparam int FLASH_MAX    = REPORT_BYTES - 20;

  localparam logic [7:0] CMD_VENDOR   = 8'h80;
  localparam logic [7:0] CMD_SUBCMD   = 8'h01;
  localparam logic [7:0] SUB_INFO     = 8'h01;
  localparam logic [7:0] SUB_STREAM   = 8'h04;
  localparam logic [7:0] SUB_NOSTREAM = 8'h05;
  localparam logic [7:0] SC_PAIR      = 8'h01;
  localparam logic [7:0] SC_DEVINFO   = 8'h02;
  localparam logic [7:0] SC_MODE      = 8'h03;
  localparam logic [7:0] SC_ELAPSED   = 8'h04;
  localparam logic [7:0] SC_FLASH     = 8'h10;
  localparam logic [7:0] SUB_REPLY_ID = 8'h21;

  localparam logic [1:0] REG_MAC      = 2'd0;
  localparam logic [1:0] REG_VID      = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [31:0] LO_BASE = 32'h2000;
  localparam logic [31:0] HI_BASE = 32'h6000;
  localparam int LO_LEN = 76;
  localparam int HI_LEN = 170;

  localparam logic [7:0] ROM_LO [LO_LEN] = '{
    8'h00, 8'h22, 8'h84, 8'h6E, 8'hDC, 8'h68, 8'hEB, 8'h69,
    8'hD4, 8'hC2, 8'h5C, 8'h61, 8'h49, 8'hE3, 8'hDE, 8'hAE,
    8'h18, 8'h52, 8'h2A, 8'h75, 8'hD3, 8'h53, 8'h14, 8'hF2,
    8'hA7, 8'hEA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h68, 8'h00, 8'h95, 8'h22,
    8'h30, 8'hB2, 8'h8C, 8'hC6, 8'h81, 8'h1A, 8'h3A, 8'h4B,
    8'h1A, 8'h1E, 8'hBB, 8'h5D, 8'h1C, 8'hC7, 8'h41, 8'hD9,
    8'h5E, 8'hC8, 8'hBA, 8'h21, 8'h18, 8'h9C, 8'hAE, 8'h3B,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h08, 8'h00
  };

  localparam logic [7:0] ROM_HI [HI_LEN] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'h03, 8'hA0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h40,
    8'h00, 8'h40, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h3B, 8'h34, 8'h3B, 8'h34, 8'h3B, 8'h34,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h06, 8'h60,
    8'h00, 8'h08, 8'h80, 8'h00, 8'h06, 8'h60, 8'h00, 8'h08,
    8'h80, 8'h00, 8'h06, 8'h60, 8'h00, 8'h06, 8'h60, 8'hFF,
    8'h42, 8'h66, 8'h3A, 8'hFF, 8'hFF, 8'hFF, 8'h4E, 8'h90,
    8'h40, 8'h4E, 8'h90, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h50, 8'hFD, 8'h00, 8'h00, 8'hC6, 8'h0F, 8'h0F, 8'h30,
    8'h61, 8'h06, 8'h30, 8'hF3, 8'hD4, 8'h14, 8'h54, 8'h41,
    8'h15, 8'h54, 8'hC7, 8'h79, 8'h9C, 8'h33, 8'h36, 8'h63,
    8'h0F, 8'h30, 8'h61, 8'h06, 8'h30, 8'hF3, 8'hD4, 8'h14,
    8'h54, 8'h41, 8'h15, 8'h54, 8'hC7, 8'h79, 8'h9C, 8'h33,
    8'h36, 8'h63
  };

  // reply job handed from the front to the back
  typedef struct packed {
    logic             is_vendor;
    logic [7:0]       sub_id;
    logic [7:0]       subcmd;
    logic [4:0][7:0]  args;
    logic             has_arg0;
    logic             has_args5;
    logic             stream;
  } ghcr_job_t;

  function automatic logic [7:0] rom_read(input logic [31:0] at);
    logic [31:0] off_lo;
    logic [31:0] off_hi;
    logic [7:0]  res;
    off_lo = at - LO_BASE;
    off_hi = at - HI_BASE;
    res    = 8'hFF;
    if (at >= LO_BASE && off_lo < 32'(LO_LEN)) begin
      res = ROM_LO[off_lo[6:0]];
    end else if (at >= HI_BASE && off_hi < 32'(HI_LEN)) begin
      res = ROM_HI[off_hi[7:0]];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/ghcr_in_if.sv
// ----------------------------------------------------------------------------
// ghcr_in_if
// Report byte channel.
// ----------------------------------------------------------------------------
interface ghcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       report_end;
  modport source (output valid, output report_byte, output report_end, input ready);
  modport sink (input valid, input report_byte, input report_end, output ready);
endinterface

>>> rtl/core/ghcr_out_if.sv
// ----------------------------------------------------------------------------
// ghcr_out_if
// Reply byte channel.
// ----------------------------------------------------------------------------
interface ghcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_end;
  logic       merge_slot;
  logic       stream_mode;
  modport source (output valid, output reply_byte, output reply_end,
                  output merge_slot, output stream_mode, input ready);
  modport sink (input valid, input reply_byte, input reply_end,
                input merge_slot, input stream_mode, output ready);
endinterface

>>> rtl/core/ghcr_cfg_if.sv
// ----------------------------------------------------------------------------
// ghcr_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ghcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [47:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/core/ghcr_front.sv
// ----------------------------------------------------------------------------
// ghcr_front
// Collects report bytes, applies the length checks and queues reply jobs.
// ----------------------------------------------------------------------------
module ghcr_front
  import ghcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic [7:0] full_mode_code,
  input  logic       q_full,
  output logic       q_push,
  output ghcr_job_t  q_job
);

  logic [7:0]      cmd_r, cmd_nxt;
  logic [7:0]      sub_r, sub_nxt;
  logic [7:0]      sc_r, sc_nxt;
  logic [4:0][7:0] arg_r, arg_nxt;
  logic [6:0]      seen_r, seen_nxt;
  logic            stream_r, stream_nxt;
  logic            take;
  logic            vend_ok, sub_ok;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd_nxt = cmd_r;
    sub_nxt = sub_r;
    sc_nxt  = sc_r;
    arg_nxt = arg_r;
    if (seen_r == 7'd0) cmd_nxt = in_byte;
    if (seen_r == 7'd1) sub_nxt = in_byte;
    if (seen_r == 7'd10) sc_nxt = in_byte;
    for (int i = 0; i < 5; i++) begin
      if (seen_r == 7'(11 + i)) arg_nxt[i] = in_byte;
    end
    seen_nxt = (seen_r == 7'd127) ? seen_r : seen_r + 7'd1;
  end

  assign vend_ok = in_end && cmd_nxt == CMD_VENDOR && seen_nxt >= 7'd2;
  assign sub_ok  = in_end && cmd_nxt == CMD_SUBCMD && seen_nxt >= 7'd11;

  always_comb begin
    stream_nxt = stream_r;
    if (vend_ok && sub_nxt == SUB_STREAM) stream_nxt = 1'b1;
    if (vend_ok && sub_nxt == SUB_NOSTREAM) stream_nxt = 1'b0;
    if (sub_ok && sc_nxt == SC_MODE) begin
      stream_nxt = seen_nxt >= 7'd12 && arg_nxt[0] == full_mode_code;
    end
  end

  assign q_push          = take && (vend_ok || sub_ok);
  assign q_job.is_vendor = vend_ok;
  assign q_job.sub_id    = sub_nxt;
  assign q_job.subcmd    = sc_nxt;
  assign q_job.args      = arg_nxt;
  assign q_job.has_arg0  = seen_nxt >= 7'd12;
  assign q_job.has_args5 = seen_nxt >= 7'd16;
  assign q_job.stream    = stream_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= '0;
      sub_r    <= '0;
      sc_r     <= '0;
      seen_r   <= '0;
      stream_r <= 1'b0;
    end else if (take) begin
      cmd_r    <= cmd_nxt;
      sub_r    <= sub_nxt;
      sc_r     <= sc_nxt;
      seen_r   <= in_end ? 7'd0 : seen_nxt;
      stream_r <= stream_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) arg_r <= arg_nxt;
  end

endmodule

>>> rtl/core/ghcr_queue.sv
// ----------------------------------------------------------------------------
// ghcr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ghcr_queue
  import ghcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ghcr_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      nonempty,
  output ghcr_job_t pop_job
);

  ghcr_job_t  slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign pop_job  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule

>>> rtl/core/ghcr_back.sv
// ----------------------------------------------------------------------------
// ghcr_back
// Plays out one reply job as a full report, one byte per transaction.
// ----------------------------------------------------------------------------
module ghcr_back
  import ghcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  ghcr_job_t   q_job,
  output logic        q_pop,
  input  logic [47:0] mac_address,
  input  logic [7:0]  vendor_reply_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end,
  output logic        out_merge,
  output logic        out_stream
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(REPORT_BYTES - 1);

  ghcr_job_t        job_r;
  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      addr_r;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             end_r, merge_r, stream_r;
  logic             advance;
  logic [7:0]       byte_nxt;
  logic [7:0]       flash_len;
  logic [IDX_W-1:0] off;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] res;
    res = 8'h00;
    case (i)
      3'd0: res = mac[7:0];
      3'd1: res = mac[15:8];
      3'd2: res = mac[23:16];
      3'd3: res = mac[31:24];
      3'd4: res = mac[39:32];
      3'd5: res = mac[47:40];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  assign advance   = !valid_r || out_ready;
  assign q_pop     = !busy_r && q_nonempty;
  assign flash_len = (job_r.args[4] > 8'(FLASH_MAX)) ? 8'(FLASH_MAX) : job_r.args[4];
  assign off       = idx_r - IDX_W'(20);

  always_comb begin
    byte_nxt = 8'h00;
    if (job_r.is_vendor) begin
      if (idx_r == '0) begin
        byte_nxt = vendor_reply_id;
      end else if (idx_r == IDX_W'(1)) begin
        byte_nxt = (job_r.sub_id == SUB_STREAM) ? SUB_NOSTREAM :
                   (job_r.sub_id == SUB_NOSTREAM) ? SUB_STREAM : job_r.sub_id;
      end else if (job_r.sub_id == SUB_INFO) begin
        if (idx_r == IDX_W'(3)) byte_nxt = 8'h03;
        if (idx_r >= IDX_W'(4) && idx_r <= IDX_W'(9)) begin
          byte_nxt = mac_byte(mac_address, 3'(IDX_W'(9) - idx_r));
        end
      end
    end else begin
      if (idx_r == '0) begin
        byte_nxt = SUB_REPLY_ID;
      end else if (idx_r == IDX_W'(13)) begin
        case (job_r.subcmd)
          SC_PAIR:    byte_nxt = 8'h81;
          SC_DEVINFO: byte_nxt = 8'h82;
          SC_ELAPSED: byte_nxt = 8'h83;
          SC_FLASH:   byte_nxt = job_r.has_args5 ? 8'h90 : 8'h80;
          default:    byte_nxt = 8'h80;
        endcase
      end else if (idx_r == IDX_W'(14)) begin
        byte_nxt = job_r.subcmd;
      end else begin
        case (job_r.subcmd)
          SC_PAIR: begin
            if (idx_r == IDX_W'(15) && job_r.has_arg0) byte_nxt = job_r.args[0];
          end
          SC_DEVINFO: begin
            if (idx_r == IDX_W'(15) || idx_r == IDX_W'(17)) byte_nxt = 8'h03;
            if (idx_r == IDX_W'(16)) byte_nxt = 8'h48;
            if (idx_r == IDX_W'(18)) byte_nxt = 8'h02;
            if (idx_r >= IDX_W'(19) && idx_r <= IDX_W'(24)) begin
              byte_nxt = mac_byte(mac_address, 3'(idx_r - IDX_W'(19)));
            end
            if (idx_r == IDX_W'(25) || idx_r == IDX_W'(26)) byte_nxt = 8'h01;
          end
          SC_ELAPSED: begin
            if (idx_r == IDX_W'(16)) byte_nxt = 8'hCC;
            if (idx_r == IDX_W'(18)) byte_nxt = 8'hEE;
            if (idx_r == IDX_W'(20)) byte_nxt = 8'hFF;
          end
          SC_FLASH: begin
            if (job_r.has_args5) begin
              if (idx_r >= IDX_W'(15) && idx_r <= IDX_W'(19)) begin
                byte_nxt = job_r.args[3'(idx_r - IDX_W'(15))];
              end
              if (idx_r >= IDX_W'(20) && 8'(off) < flash_len) begin
                byte_nxt = rom_read(addr_r);
              end
            end
          end
          default: byte_nxt = 8'h00;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (busy_r && advance) begin
        valid_r <= 1'b1;
        idx_r   <= idx_r + IDX_W'(1);
        if (idx_r == LAST) busy_r <= 1'b0;
      end else if (advance) begin
        valid_r <= 1'b0;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && advance) begin
      byte_r   <= byte_nxt;
      end_r    <= idx_r == LAST;
      merge_r  <= !job_r.is_vendor && idx_r >= IDX_W'(1) && idx_r <= IDX_W'(12);
      stream_r <= job_r.stream;
      // step the flash address once the data bytes start
      if (idx_r >= IDX_W'(20)) addr_r <= addr_r + 32'd1;
    end
    if (q_pop) begin
      job_r  <= q_job;
      addr_r <= {q_job.args[3], q_job.args[2], q_job.args[1], q_job.args[0]};
    end
  end

  assign out_valid  = valid_r;
  assign out_byte   = byte_r;
  assign out_end    = end_r;
  assign out_merge  = merge_r;
  assign out_stream = stream_r;

endmodule

>>> rtl/core/gamepad_host_command_responder_unit.sv
// ----------------------------------------------------------------------------
// gamepad_host_command_responder_unit
// Host output report parser and reply report generator.
// ----------------------------------------------------------------------------
// Report bytes are taken one per cycle. A report that calls for a reply queues
// a job in a two-entry queue; the back end then sends a 64-byte reply, one
// byte per cycle while out_ch.ready is high; the output goes idle between
// replies. Input stalls only while two replies are waiting, so the output
// drain rate bounds how often replying reports may arrive. Register writes
// are always accepted and take effect at once.
module gamepad_host_command_responder_unit
  import ghcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  ghcr_in_if.sink    in_ch,
  ghcr_out_if.source out_ch,
  ghcr_cfg_if.sink   cfg_ch
);

  logic [47:0] mac_r;
  logic [7:0]  vid_r;
  logic [7:0]  mode_r;
  logic        q_full, q_push, q_pop, q_nonempty;
  ghcr_job_t   push_job, pop_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r  <= '0;
      vid_r  <= 8'h81;
      mode_r <= 8'h30;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_MAC:  mac_r <= cfg_ch.wdata;
        REG_VID:  vid_r <= cfg_ch.wdata[7:0];
        REG_MODE: mode_r <= cfg_ch.wdata[7:0];
        default:  ;
      endcase
    end
  end

  ghcr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_byte        (in_ch.report_byte),
    .in_end         (in_ch.report_end),
    .full_mode_code (mode_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  ghcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_job  (pop_job)
  );

  ghcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .mac_address     (mac_r),
    .vendor_reply_id (vid_r),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.reply_byte),
    .out_end         (out_ch.reply_end),
    .out_merge       (out_ch.merge_slot),
    .out_stream      (out_ch.stream_mode)
  );

endmodule

>>> dv/ghcr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghcr_checker
// Watches the report, reply and register channels of the responder, works out
// the reply bytes each accepted report calls for and compares every accepted
// reply transaction with the oldest one still owed.
// ----------------------------------------------------------------------------
module ghcr_checker
  import ghcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ghcr_in_if   in_mon,
  ghcr_out_if  out_mon,
  ghcr_cfg_if  cfg_mon,
  output int   fail_count,
  output int   beats_owed
);

  localparam logic [7:0] ACK_PLAIN   = 8'h80;
  localparam logic [7:0] ACK_PAIR    = 8'h81;
  localparam logic [7:0] ACK_DEVINFO = 8'h82;
  localparam logic [7:0] ACK_ELAPSED = 8'h83;
  localparam logic [7:0] ACK_FLASH   = 8'h90;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       merge;
    logic       stream;
  } reply_beat_t;

  reply_beat_t reply_q[$];

  logic [47:0] mac;
  logic [7:0]  vendor_id;
  logic [7:0]  full_code;
  logic [7:0]  cmd;
  logic [7:0]  sid;
  logic [7:0]  subcmd;
  logic [7:0]  args [5];
  logic [6:0]  seen;
  logic        streaming;

  function automatic logic [7:0] flash_byte(input logic [31:0] at);
    logic [7:0] val;
    val = 8'hFF;
    if (at >= LO_BASE && (at - LO_BASE) < 32'(LO_LEN)) begin
      val = ROM_LO[int'(at - LO_BASE)];
    end else if (at >= HI_BASE && (at - HI_BASE) < 32'(HI_LEN)) begin
      val = ROM_HI[int'(at - HI_BASE)];
    end
    return val;
  endfunction

  task automatic push_reply(input logic [7:0] rep [REPORT_BYTES], input logic merge);
    for (int k = 0; k < REPORT_BYTES; k++) begin
      reply_q.push_back('{rep[k], k == REPORT_BYTES - 1, merge && k >= 1 && k <= 12,
                          streaming});
    end
  endtask

  task automatic answer_report(input int n);
    logic [7:0]  rep [REPORT_BYTES];
    logic [31:0] addr;
    int          len;
    int          nargs;
    foreach (rep[k]) rep[k] = 8'h00;
    if (cmd == CMD_VENDOR && n >= 2) begin
      rep[0] = vendor_id;
      rep[1] = sid;
      case (sid)
        SUB_INFO: begin
          rep[3] = 8'h03;
          for (int i = 0; i < 6; i++) rep[4 + i] = mac[8 * (5 - i) +: 8];
        end
        SUB_STREAM: begin
          streaming = 1'b1;
          rep[1]    = SUB_NOSTREAM;
        end
        SUB_NOSTREAM: begin
          streaming = 1'b0;
          rep[1]    = SUB_STREAM;
        end
        default: ;
      endcase
      push_reply(rep, 1'b0);
    end else if (cmd == CMD_SUBCMD && n >= 11) begin
      nargs   = n - 11;
      rep[0]  = SUB_REPLY_ID;
      rep[13] = ACK_PLAIN;
      rep[14] = subcmd;
      case (subcmd)
        SC_PAIR: begin
          rep[13] = ACK_PAIR;
          rep[15] = (nargs > 0) ? args[0] : 8'h00;
        end
        SC_DEVINFO: begin
          rep[13] = ACK_DEVINFO;
          rep[15] = 8'h03;
          rep[16] = 8'h48;
          rep[17] = 8'h03;
          rep[18] = 8'h02;
          for (int i = 0; i < 6; i++) rep[19 + i] = mac[8 * i +: 8];
          rep[25] = 8'h01;
          rep[26] = 8'h01;
        end
        SC_MODE: streaming = (nargs > 0 && args[0] == full_code);
        SC_ELAPSED: begin
          rep[13] = ACK_ELAPSED;
          rep[16] = 8'hCC;
          rep[18] = 8'hEE;
          rep[20] = 8'hFF;
        end
        SC_FLASH: begin
          if (nargs >= 5) begin
            addr    = {args[3], args[2], args[1], args[0]};
            len     = (int'(args[4]) > FLASH_MAX) ? FLASH_MAX : int'(args[4]);
            rep[13] = ACK_FLASH;
            for (int i = 0; i < 5; i++) rep[15 + i] = args[i];
            for (int i = 0; i < len; i++) rep[20 + i] = flash_byte(addr + 32'(i));
          end
        end
        default: ;
      endcase
      push_reply(rep, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    int          n;
    if (!rst_n) begin
      mac        = '0;
      vendor_id  = 8'h81;
      full_code  = 8'h30;
      cmd        = '0;
      sid        = '0;
      subcmd     = '0;
      seen       = '0;
      streaming  = 1'b0;
      fail_count = 0;
      reply_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_MAC:  mac       = cfg_mon.wdata;
          REG_VID:  vendor_id = cfg_mon.wdata[7:0];
          REG_MODE: full_code = cfg_mon.wdata[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected reply byte: expected none got %h", $time,
                   out_mon.reply_byte);
        end else begin
          want = reply_q.pop_front();
          if (out_mon.reply_byte !== want.data || out_mon.reply_end !== want.last ||
              out_mon.merge_slot !== want.merge || out_mon.stream_mode !== want.stream) begin
            fail_count++;
            $display("%0t reply mismatch: expected byte %h end %b merge %b stream %b,",
                     $time, want.data, want.last, want.merge, want.stream,
                     " got byte %h end %b merge %b stream %b",
                     out_mon.reply_byte, out_mon.reply_end, out_mon.merge_slot,
                     out_mon.stream_mode);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (seen)
          7'd0:  cmd    = in_mon.report_byte;
          7'd1:  sid    = in_mon.report_byte;
          7'd10: subcmd = in_mon.report_byte;
          default: begin
            if (seen >= 7'd11 && seen <= 7'd15) args[seen - 7'd11] = in_mon.report_byte;
          end
        endcase
        if (seen < 7'd127) seen++;
        if (in_mon.report_end) begin
          n    = int'(seen);
          seen = '0;
          answer_report(n);
        end
      end
    end
    beats_owed = reply_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives host reports and register writes into the responder under shifting
// stall patterns; the checker beside it predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb;
  import ghcr_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_fire;
  logic out_fire;
  logic cfg_fire;
  int   fail_count;
  int   beats_owed;
  int   src_idle;
  int   snk_idle;
  int   bytes_sent;
  int   quiet_cycles;

  ghcr_in_if  in_ch ();
  ghcr_out_if out_ch ();
  ghcr_cfg_if cfg_ch ();

  gamepad_host_command_responder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ghcr_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .beats_owed (beats_owed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    cfg_fire <= rst_n && cfg_ch.valid && cfg_ch.ready;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  // watchdog: restart on any transaction
  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.report_byte <= b;
    in_ch.report_end  <= last;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_report(input logic [7:0] q [$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (beats_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_regs(input logic [47:0] mac, input logic [7:0] vid,
                            input logic [7:0] mode);
    wait_drained();
    write_reg(REG_MAC, mac);
    write_reg(REG_VID, {40'd0, vid});
    write_reg(REG_MODE, {40'd0, mode});
  endtask

  // subcommand report: header, subcommand at position 10, arguments after it
  task automatic sub_report(input logic [7:0] sc, input logic [7:0] a [5], input int total);
    logic [7:0] q [$];
    q.push_back(CMD_SUBCMD);
    while (q.size() < 10) q.push_back(8'($urandom));
    q.push_back(sc);
    for (int i = 0; q.size() < total; i++) q.push_back(i < 5 ? a[i] : 8'($urandom));
    send_report(q);
  endtask

  task automatic random_report(input logic [7:0] mode);
    logic [7:0]  q [$];
    logic [7:0]  a [5];
    logic [7:0]  sc;
    logic [31:0] addr;
    int          pick;
    int          total;
    pick = $urandom_range(99);
    foreach (a[i]) a[i] = 8'($urandom);
    if (pick < 25) begin
      case ($urandom_range(4))
        0: q = {CMD_VENDOR, SUB_INFO};
        1: q = {CMD_VENDOR, SUB_STREAM};
        2: q = {CMD_VENDOR, SUB_NOSTREAM};
        3: q = {CMD_VENDOR};
        default: q = {CMD_VENDOR, 8'($urandom)};
      endcase
      repeat ($urandom_range(2)) q.push_back(8'($urandom));
      send_report(q);
    end else if (pick < 85) begin
      case ($urandom_range(6))
        0: sc = SC_PAIR;
        1: sc = SC_DEVINFO;
        2: begin
          sc = SC_MODE;
          if ($urandom_range(1)) a[0] = mode;
        end
        3: sc = SC_ELAPSED;
        4, 5: begin
          sc = SC_FLASH;
          case ($urandom_range(3))
            0: addr = LO_BASE - 32'd8 + 32'($urandom_range(90));
            1: addr = HI_BASE - 32'd8 + 32'($urandom_range(185));
            2: addr = 32'hFFFF_FFF0 + 32'($urandom_range(15));
            default: addr = $urandom;
          endcase
          {a[3], a[2], a[1], a[0]} = addr;
          if ($urandom_range(1)) a[4] = 8'($urandom_range(FLASH_MAX + 4));
        end
        default: sc = 8'($urandom);
      endcase
      pick = $urandom_range(99);
      if (pick < 80)      total = $urandom_range(11, 17);
      else if (pick < 92) total = $urandom_range(18, 40);
      else if (pick < 97) total = $urandom_range(1, 10);
      else                total = $urandom_range(126, 132);
      sub_report(sc, a, total);
    end else begin
      q.push_back(8'($urandom));
      repeat ($urandom_range(12)) q.push_back(8'($urandom));
      send_report(q);
    end
  endtask

  task automatic random_phase(input int n_bytes, input logic [7:0] mode, input logic hold);
    int goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      random_report(mode);
      if (hold && bytes_sent > goal - n_bytes / 2) begin
        // hold off until every owed reply has gone out
        while (beats_owed != 0) @(negedge clk);
        hold = 1'b0;
      end
    end
  endtask

  initial begin
    logic [7:0] a [5];
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.report_byte = '0;
    in_ch.report_end  = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.reg_index  = REG_MAC;
    cfg_ch.wdata      = '0;
    out_ch.ready      = 1'b0;
    src_idle          = 26;
    snk_idle          = 83;
    bytes_sent        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    setup_regs(48'({$urandom, $urandom}), 8'h81, 8'h30);
    send_report({CMD_VENDOR, SUB_INFO});
    send_report({CMD_VENDOR, SUB_STREAM});
    send_report({CMD_VENDOR, SUB_NOSTREAM, 8'h00});
    send_report({CMD_VENDOR});
    send_report({8'h10, 8'h00, 8'hFF});
    send_report({CMD_SUBCMD, 8'h07, 8'hFF, 8'h00});
    a = '{8'hAB, 8'h00, 8'h00, 8'h00, 8'h00};
    sub_report(SC_PAIR, a, 12);
    a = '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00};
    sub_report(SC_MODE, a, 12);
    sub_report(SC_MODE, a, 11);
    a = '{8'h00, 8'h20, 8'h00, 8'h00, 8'hFF};
    sub_report(SC_FLASH, a, 16);
    sub_report(SC_FLASH, a, 14);
    send_report({8'hFF, 8'hFF});
    random_phase(36, 8'h30, 1'b0);

    src_idle = 83;
    snk_idle = 26;
    setup_regs(48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF);
    random_phase(36, 8'hFF, 1'b0);

    src_idle = 0;
    snk_idle = 0;
    setup_regs(48'h0, 8'h00, 8'h00);
    random_phase(36, 8'h00, 1'b1);

    while (beats_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ghcr_pkg.sv
rtl/core/ghcr_in_if.sv
rtl/core/ghcr_out_if.sv
rtl/core/ghcr_cfg_if.sv
rtl/core/ghcr_front.sv
rtl/core/ghcr_queue.sv
rtl/core/ghcr_back.sv
rtl/core/gamepad_host_command_responder_unit.sv
dv/ghcr_checker.sv
dv/tb.sv
